### rtl/greedy_word_wrap_breaker_macros.svh
// assertion macros used by the checker file
`ifndef GREEDY_WORD_WRAP_BREAKER_MACROS_SVH
`define GREEDY_WORD_WRAP_BREAKER_MACROS_SVH

// clocked assertion, held off while reset is asserted
`define GWWB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// clocked assertion that is checked during reset too
`define GWWB_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

### rtl/gwwb_pkg.sv
// types and constants of the greedy word wrap line breaker
`default_nettype none

package gwwb_pkg;

  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned ADV_W   = 16;
  localparam int unsigned WIDTH_W = 24;
  localparam int unsigned POS_W   = 10;

  localparam logic [CHAR_W-1:0]  CHAR_NUL     = 8'd0;
  localparam logic [CHAR_W-1:0]  CHAR_NEWLINE = 8'd10;
  localparam logic [CHAR_W-1:0]  CHAR_SPACE   = 8'd32;
  localparam logic [WIDTH_W-1:0] WIDTH_SAT    = {WIDTH_W{1'b1}};

  typedef struct packed {
    logic [CHAR_W-1:0] char_code;
    logic [ADV_W-1:0]  glyph_advance;
    logic              end_of_text;
  } item_t;

  typedef struct packed {
    logic [POS_W-1:0] break_position;
    logic             is_text_end;
  } brk_t;

  // up to two breaks caused by one item, in output order
  typedef struct packed {
    logic two;
    brk_t first;
    brk_t second;
  } res_t;

endpackage

`default_nettype wire

### rtl/gwwb_core.sv
// input register, line state and break decision of the word wrap breaker
`default_nettype none

module gwwb_core #(
  parameter int unsigned MAX_CHARS = 1024
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [gwwb_pkg::WIDTH_W-1:0]  cfg_wdata_i,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire gwwb_pkg::item_t               in_item_i,
  input  wire logic                          res_free_i,
  output logic                               res_load_o,
  output gwwb_pkg::res_t                     res_o
);
  import gwwb_pkg::*;

  localparam int unsigned IDX_W = $clog2(MAX_CHARS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_CHARS - 1);

  logic               in_valid_q, in_valid_d;
  item_t              in_item_q;
  logic [WIDTH_W-1:0] wrap_q;
  logic [IDX_W-1:0]   idx_q, idx_d;
  logic [IDX_W-1:0]   ws_q, ws_d;
  logic [WIDTH_W-1:0] pen_q, pen_d;
  logic [WIDTH_W-1:0] word_q, word_d;

  logic               fire;
  logic               res_any;
  logic               a_hit, b_hit, b_end;
  logic [IDX_W-1:0]   a_idx, b_idx;
  logic [IDX_W+POS_W-1:0] a_ext, b_ext;
  logic [WIDTH_W:0]   line_sum;
  logic [WIDTH_W:0]   word_adv;
  logic [WIDTH_W-1:0] word_adv_sat;
  logic [WIDTH_W:0]   pen_adv;
  logic [WIDTH_W-1:0] pen_adv_sat;
  logic               wrap_on, over_ge, over_gt, ws_nz;

  // arithmetic on the current state
  assign line_sum     = {1'b0, pen_q} + {1'b0, word_q};
  assign word_adv     = {1'b0, word_q} + {{(WIDTH_W+1-ADV_W){1'b0}}, in_item_q.glyph_advance};
  assign word_adv_sat = word_adv[WIDTH_W] ? WIDTH_SAT : word_adv[WIDTH_W-1:0];
  assign pen_adv      = {1'b0, pen_q} + {1'b0, word_adv_sat};
  assign pen_adv_sat  = pen_adv[WIDTH_W] ? WIDTH_SAT : pen_adv[WIDTH_W-1:0];
  assign wrap_on      = (wrap_q != '0);
  assign over_ge      = (line_sum >= {1'b0, wrap_q});
  assign over_gt      = (line_sum > {1'b0, wrap_q});
  assign ws_nz        = (ws_q != '0);

  always_comb begin
    a_hit  = 1'b0;
    b_hit  = 1'b0;
    b_end  = 1'b0;
    a_idx  = ws_q;
    b_idx  = idx_q;
    idx_d  = idx_q;
    ws_d   = ws_q;
    pen_d  = pen_q;
    word_d = word_q;
    priority if (in_item_q.end_of_text) begin
      a_hit  = wrap_on && over_gt && ws_nz;
      b_hit  = 1'b1;
      b_end  = 1'b1;
      idx_d  = '0;
      ws_d   = '0;
      pen_d  = '0;
      word_d = '0;
    end else if ((in_item_q.char_code != CHAR_NUL) && (idx_q < LAST_IDX)) begin
      idx_d = idx_q + 1'b1;
      if (wrap_on) begin
        unique case (in_item_q.char_code)
          CHAR_NEWLINE: begin
            a_hit  = over_ge && ws_nz;
            b_hit  = (idx_q != '0);
            pen_d  = '0;
            ws_d   = idx_q + 1'b1;
            word_d = '0;
          end
          CHAR_SPACE: begin
            a_hit  = over_ge && ws_nz;
            pen_d  = over_ge ? word_adv_sat : pen_adv_sat;
            ws_d   = idx_q + 1'b1;
            word_d = '0;
          end
          default: begin
            word_d = word_adv_sat;
          end
        endcase
      end
    end else begin
      // dropped character, the line state stays
      idx_d = idx_q;
    end
  end

  // positions keep their low bits only
  assign a_ext = {{POS_W{1'b0}}, a_idx};
  assign b_ext = {{POS_W{1'b0}}, b_idx};

  always_comb begin
    res_o.two                    = a_hit && b_hit;
    res_o.second.break_position  = b_ext[POS_W-1:0];
    res_o.second.is_text_end     = b_end;
    if (a_hit) begin
      res_o.first.break_position = a_ext[POS_W-1:0];
      res_o.first.is_text_end    = 1'b0;
    end else begin
      res_o.first.break_position = b_ext[POS_W-1:0];
      res_o.first.is_text_end    = b_end;
    end
  end

  // an item without breaks never waits on the result register
  assign res_any    = a_hit || b_hit;
  assign fire       = in_valid_q && (!res_any || res_free_i);
  assign res_load_o = fire && res_any;
  assign in_ready_o = !in_valid_q || fire;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_valid_i && in_ready_o) begin
      in_valid_d = 1'b1;
    end else if (fire) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      wrap_q     <= '0;
      idx_q      <= '0;
      ws_q       <= '0;
      pen_q      <= '0;
      word_q     <= '0;
    end else begin
      in_valid_q <= in_valid_d;
      if (cfg_we_i) begin
        wrap_q <= cfg_wdata_i;
      end
      if (fire) begin
        idx_q  <= idx_d;
        ws_q   <= ws_d;
        pen_q  <= pen_d;
        word_q <= word_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_item_q <= in_item_i;
    end
  end

endmodule

`default_nettype wire

### rtl/gwwb_out_buf.sv
// result register holding up to two breaks, sent out one beat at a time
`default_nettype none

module gwwb_out_buf (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        load_i,
  input  wire gwwb_pkg::res_t              res_i,
  output logic                             free_o,
  output logic                             valid_o,
  input  wire logic                        ready_i,
  output gwwb_pkg::brk_t                   brk_o,
  output logic                             last_o
);
  import gwwb_pkg::*;

  logic valid_q, valid_d;
  logic sel_q, sel_d;
  logic two_q;
  brk_t first_q, second_q;
  logic pop, done;

  assign brk_o   = sel_q ? second_q : first_q;
  assign last_o  = two_q ? sel_q : 1'b1;
  assign valid_o = valid_q;
  assign pop     = valid_q && ready_i;
  assign done    = pop && last_o;
  assign free_o  = !valid_q || done;

  always_comb begin
    valid_d = valid_q;
    sel_d   = sel_q;
    if (load_i) begin
      valid_d = 1'b1;
      sel_d   = 1'b0;
    end else if (done) begin
      valid_d = 1'b0;
      sel_d   = 1'b0;
    end else if (pop) begin
      sel_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      sel_q   <= 1'b0;
      two_q   <= 1'b0;
    end else begin
      valid_q <= valid_d;
      sel_q   <= sel_d;
      if (load_i) begin
        two_q <= res_i.two;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      first_q  <= res_i.first;
      second_q <= res_i.second;
    end
  end

endmodule

`default_nettype wire

### rtl/greedy_word_wrap_breaker.sv
// top level of the greedy word wrap line breaker
`default_nettype none

// Greedy word wrap line breaker. Characters stream in one per beat with their
// glyph advance in Q10.6; a beat with tlast set closes the text. Out come the
// character indices at which new lines begin, one per beat, followed by the
// text length flagged in tuser. Each input beat is registered, then the pen
// and word bookkeeping (a 25-bit add and compare beside two chained saturating
// adds) is done combinationally and its breaks land in a two-entry result
// register. Throughput is one character per clock as long as results are taken;
// an item that causes two breaks (a newline that also wraps, or a text end that
// wraps) occupies the result register for two output beats, so a following item
// that itself breaks waits there until the second beat is taken. An input beat
// passes the input register, then the result register, before its first break
// comes out. Writing wrap_width is only meant while idle; zero turns wrapping
// off and only the text length is reported. Characters beyond MAX_CHARS - 1
// and code zero are dropped.

module greedy_word_wrap_breaker #(
  parameter int unsigned MAX_CHARS = 1024
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration: wrap width in Q18.6
  input  wire logic        cfg_we_i,
  input  wire logic [23:0] cfg_wdata_i,
  // character stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,   // [7:0] char_code, [23:8] glyph_advance
  input  wire logic        s_axis_tlast,   // end_of_text
  // break stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,   // [9:0] break_position, [15:10] zero
  output logic             m_axis_tuser,   // is_text_end
  output logic             m_axis_tlast    // last_of_run
);
  import gwwb_pkg::*;

  item_t in_item;
  res_t  res;
  brk_t  out_brk;
  logic  res_load;
  logic  res_free;

  // unpack the input beat
  assign in_item.char_code     = s_axis_tdata[CHAR_W-1:0];
  assign in_item.glyph_advance = s_axis_tdata[CHAR_W+ADV_W-1:CHAR_W];
  assign in_item.end_of_text   = s_axis_tlast;

  gwwb_core #(
    .MAX_CHARS (MAX_CHARS)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_item_i   (in_item),
    .res_free_i  (res_free),
    .res_load_o  (res_load),
    .res_o       (res)
  );

  // holds the breaks of one item until all are taken
  gwwb_out_buf u_out_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (res_load),
    .res_i   (res),
    .free_o  (res_free),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .brk_o   (out_brk),
    .last_o  (m_axis_tlast)
  );

  // pack the output beat, padded to whole bytes
  assign m_axis_tdata = {{(16-POS_W){1'b0}}, out_brk.break_position};
  assign m_axis_tuser = out_brk.is_text_end;

endmodule

`default_nettype wire

### rtl/gwwb_checker.sv
// port-level checker for the word wrap breaker and its bind
`default_nettype none

`include "greedy_word_wrap_breaker_macros.svh"

module gwwb_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [15:0] m_axis_tdata,
  input wire logic        m_axis_tuser,
  input wire logic        m_axis_tlast
);

  // a stalled break beat keeps its payload
  `GWWB_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "stalled break beat changed")

  // the text length always closes its run
  `GWWB_ASSERT(a_end_is_last, m_axis_tvalid && m_axis_tuser |-> m_axis_tlast, "text end not marked last")

  // the second break of a pair is ready right after the first
  `GWWB_ASSERT(a_pair_follows, m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid, "second break of a pair missing")

  // nothing comes out while reset is asserted
  `GWWB_ASSERT_ALWAYS(a_rst_quiet, !rst_ni |-> !m_axis_tvalid, "break beat during reset")

endmodule

bind greedy_word_wrap_breaker gwwb_checker u_gwwb_checker (.*);

`default_nettype wire
